// ----- rtl/mefr_pkg.sv -----
// shared types and constants for the multichannel ema filter framer
// no dependencies; imported by every module of the block
package mefr_pkg;

  localparam int CHANNEL_COUNT = 6;
  localparam int SAMPLE_BITS   = 12;
  localparam int IDX_BITS      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int SNAP_BITS     = CHANNEL_COUNT * SAMPLE_BITS;
  localparam int BYTE_COUNT    = 2 * CHANNEL_COUNT + 4;
  localparam int CNT_BITS      = $clog2(BYTE_COUNT);
  localparam int SUM_BITS      = SAMPLE_BITS + 8;

  localparam logic [SAMPLE_BITS-1:0] MIDSCALE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [7:0] HEADER_A = 8'hAA;
  localparam logic [7:0] HEADER_B = 8'h55;

  typedef struct packed {
    logic [2:0]  channel_index;
    logic [11:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } out_word_t;

  typedef struct packed {
    logic [2:0] filter_shift;
    logic [2:0] quant_bits;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/multichannel_ema_filter_framer_unit.sv -----
// top level of the multichannel ema filter framer: config registers,
// front end, snapshot queue and frame serializer; uses mefr_pkg
//
// usage:
//   sample channel (sample_valid / sample_stall / sample_word) takes one
//   converter reading tagged with its channel. an index past the last
//   channel is dropped. each sample updates its channel's filtered value
//   at the edge it is accepted, so samples go in one per cycle while the
//   snapshot queue has room.
//   the sample of the last channel pushes a snapshot of all channels; the
//   serializer turns it into 2*channels+4 frame words, one per cycle
//   while frame_stall is low, the checksum word marked by frame_last.
//   the snapshot passes the queue and the serializer's shift register
//   before its first word is registered onto frame_valid. the serializer
//   takes a snapshot only when idle, so the sustained input rate is set
//   by its one-word-per-cycle output register. frame_stall holds the
//   output word; the queue keeps two snapshots, after which sample_stall
//   goes high. reset (rst, synchronous) sets every channel to midscale,
//   drops queued frames and loads the register defaults. the user must
//   make apb writes only while idle; the block does not enforce it.
module multichannel_ema_filter_framer_unit import mefr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  in_word_t    sample_word,
  output logic        frame_valid,
  input  logic        frame_stall,
  output out_word_t   frame_word
);

  localparam logic REG_FILTER_SHIFT = 1'b0;
  localparam logic REG_QUANT_BITS   = 1'b1;

  cfg_t                 cfg;
  q_stat_t              q_stat;
  logic                 push;
  logic                 pop;
  logic [SNAP_BITS-1:0] push_data;
  logic [SNAP_BITS-1:0] pop_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_shift <= 3'd3;
      cfg.quant_bits   <= 3'd2;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_FILTER_SHIFT: cfg.filter_shift <= pwdata[2:0];
        REG_QUANT_BITS:   cfg.quant_bits   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FILTER_SHIFT: prdata = {29'd0, cfg.filter_shift};
      REG_QUANT_BITS:   prdata = {29'd0, cfg.quant_bits};
      default:          prdata = 32'd0;
    endcase
  end

  mefr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_word  (sample_word),
    .q_stat       (q_stat),
    .push         (push),
    .push_data    (push_data)
  );

  mefr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  mefr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .pop_data    (pop_data),
    .pop         (pop),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_word  (frame_word)
  );

endmodule

// ----- rtl/mefr_front.sv -----
// front end: accepts samples, updates the per-channel filter state
// and pushes a snapshot of all channels to the frame queue; uses mefr_pkg
module mefr_front import mefr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  in_word_t             sample_word,
  input  q_stat_t              q_stat,
  output logic                 push,
  output logic [SNAP_BITS-1:0] push_data
);

  logic [SAMPLE_BITS-1:0] vals [CHANNEL_COUNT];
  logic                   accept;
  logic                   in_range;
  logic [IDX_BITS-1:0]    idx;
  logic [SAMPLE_BITS-1:0] old;
  logic [SAMPLE_BITS-1:0] sample;
  logic [SUM_BITS-1:0]    scaled;
  logic [SUM_BITS-1:0]    shifted;
  logic [SAMPLE_BITS-1:0] qmask;
  logic [SAMPLE_BITS-1:0] next_val;

  assign sample_stall = q_stat.full;
  assign accept       = sample_valid && !sample_stall;
  assign in_range     = 32'(sample_word.channel_index) < CHANNEL_COUNT;
  assign idx          = IDX_BITS'(sample_word.channel_index);
  assign old          = vals[idx];
  assign sample       = SAMPLE_BITS'(sample_word.sample_value);

  // old * (2^k - 1) + sample, done as a shift and subtract
  always_comb begin
    scaled   = (SUM_BITS'(old) << cfg.filter_shift) - SUM_BITS'(old) + SUM_BITS'(sample);
    shifted  = scaled >> cfg.filter_shift;
    qmask    = {SAMPLE_BITS{1'b1}} << cfg.quant_bits;
    next_val = shifted[SAMPLE_BITS-1:0] & qmask;
  end

  assign push = accept && in_range &&
                (32'(sample_word.channel_index) == CHANNEL_COUNT - 1);

  // snapshot carries the value written at this same edge
  always_comb begin
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      if (idx == IDX_BITS'(i)) begin
        push_data[i*SAMPLE_BITS +: SAMPLE_BITS] = next_val;
      end else begin
        push_data[i*SAMPLE_BITS +: SAMPLE_BITS] = vals[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        vals[i] <= MIDSCALE;
      end
    end else if (accept && in_range) begin
      vals[idx] <= next_val;
    end
  end

endmodule

// ----- rtl/mefr_queue.sv -----
// two-entry queue of channel snapshots between front and back end
// uses mefr_pkg for widths and the status struct
module mefr_queue import mefr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [SNAP_BITS-1:0] push_data,
  input  logic                 pop,
  output logic [SNAP_BITS-1:0] pop_data,
  output q_stat_t              q_stat
);

  logic [SNAP_BITS-1:0] mem [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;

  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);
  assign pop_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full && !pop))
    else $error("snapshot pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_stat.empty))
    else $error("snapshot popped from an empty queue");
`endif

endmodule

// ----- rtl/mefr_back.sv -----
// back end: turns one snapshot into a frame of header, count, values and xor
// checksum, one word per unstalled cycle to an output register; uses mefr_pkg
module mefr_back import mefr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  q_stat_t              q_stat,
  input  logic [SNAP_BITS-1:0] pop_data,
  output logic                 pop,
  output logic                 frame_valid,
  input  logic                 frame_stall,
  output out_word_t            frame_word
);

  localparam logic [CNT_BITS-1:0] POS_HDR_A = CNT_BITS'(0);
  localparam logic [CNT_BITS-1:0] POS_HDR_B = CNT_BITS'(1);
  localparam logic [CNT_BITS-1:0] POS_COUNT = CNT_BITS'(2);
  localparam logic [CNT_BITS-1:0] POS_SUM   = CNT_BITS'(BYTE_COUNT - 1);

  logic                   busy;
  logic [CNT_BITS-1:0]    cnt;
  logic [SNAP_BITS-1:0]   shreg;
  logic [7:0]             sum;
  logic                   load;
  logic [SAMPLE_BITS-1:0] cur;
  logic [7:0]             byte_val;
  logic                   byte_last;

  assign pop  = !busy && !q_stat.empty;
  assign load = busy && (!frame_valid || !frame_stall);
  assign cur  = shreg[SAMPLE_BITS-1:0];

  always_comb begin
    byte_last = 1'b0;
    case (cnt)
      POS_HDR_A: byte_val = HEADER_A;
      POS_HDR_B: byte_val = HEADER_B;
      POS_COUNT: byte_val = 8'(CHANNEL_COUNT);
      POS_SUM: begin
        byte_val  = sum;
        byte_last = 1'b1;
      end
      default: begin
        // value bytes: odd positions carry the high byte
        if (cnt[0]) begin
          byte_val = 8'(cur >> 8);
        end else begin
          byte_val = cur[7:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shreg <= pop_data;
      sum   <= 8'h00;
    end else if (load) begin
      sum <= sum ^ byte_val;
      if (cnt != POS_SUM && cnt > POS_COUNT && !cnt[0]) begin
        shreg <= shreg >> SAMPLE_BITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (load) begin
      if (cnt == POS_SUM) begin
        busy <= 1'b0;
        cnt  <= '0;
      end else begin
        cnt <= cnt + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (load) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_word.frame_byte <= byte_val;
      frame_word.frame_last <= byte_last;
    end
  end

`ifndef SYNTHESIS
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !busy |-> cnt == '0)
    else $error("byte counter not cleared while idle");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (load && cnt == POS_SUM) |=> !busy && frame_valid && frame_word.frame_last)
    else $error("checksum word did not close the frame");
`endif

endmodule

// ----- sim/multichannel_ema_filter_framer_unit_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for multichannel_ema_filter_framer_unit: predicts each
// frame from the accepted samples and checks every frame word; uses mefr_pkg
module multichannel_ema_filter_framer_unit_tb;
  import mefr_pkg::*;

  localparam logic [2:0] ADDR_FILTER_SHIFT = 3'd0;
  localparam logic [2:0] ADDR_QUANT_BITS   = 3'd4;
  localparam int         STALL_LIMIT       = 2000;
  localparam int         SETTLE_CYCLES     = 8;
  localparam int         DRAIN_CYCLES      = 24;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        sample_valid;
  logic        sample_stall;
  in_word_t    sample_word;
  logic        frame_valid;
  logic        frame_stall;
  out_word_t   frame_word;

  // predictor state
  logic [SAMPLE_BITS-1:0] chan_level [CHANNEL_COUNT];
  logic [2:0]             shift_k;
  logic [2:0]             quant_q;
  out_word_t              frame_bytes_due [$];

  int  mismatch_count;
  int  quiet_cycles;
  bit  src_idle_on;
  bit  sink_idle_on;
  bit  sink_hold;
  int  sink_run;

  multichannel_ema_filter_framer_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_word  (sample_word),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_word   (frame_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  // mostly zero, some short, a few long
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [11:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 12'h000;
    if (r == 1) return 12'hFFF;
    return 12'($urandom_range(0, 4095));
  endfunction

  // filter update for one sample, and the frame it triggers on the last channel
  task automatic filter_and_frame(input in_word_t w);
    int unsigned old_v;
    int unsigned nxt;
    logic [7:0]  fb [BYTE_COUNT];
    logic [7:0]  csum;
    out_word_t   ob;
    if (w.channel_index >= CHANNEL_COUNT) return;
    old_v = chan_level[w.channel_index];
    nxt = (old_v * ((32'd1 << shift_k) - 32'd1) + w.sample_value) >> shift_k;
    nxt = nxt & ~((32'd1 << quant_q) - 32'd1);
    chan_level[w.channel_index] = nxt[SAMPLE_BITS-1:0];
    if (w.channel_index != CHANNEL_COUNT - 1) return;
    fb[0] = HEADER_A;
    fb[1] = HEADER_B;
    fb[2] = 8'(CHANNEL_COUNT);
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      fb[3 + 2*i] = 8'(chan_level[i] >> 8);
      fb[4 + 2*i] = chan_level[i][7:0];
    end
    csum = 8'h00;
    for (int j = 0; j < BYTE_COUNT - 1; j++) begin
      csum = csum ^ fb[j];
    end
    fb[BYTE_COUNT-1] = csum;
    for (int j = 0; j < BYTE_COUNT; j++) begin
      ob.frame_byte = fb[j];
      ob.frame_last = (j == BYTE_COUNT - 1);
      frame_bytes_due.push_back(ob);
    end
  endtask

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_sample(input logic [2:0] ch, input logic [11:0] val);
    int       gap;
    in_word_t w;
    w.channel_index = ch;
    w.sample_value  = val;
    gap = src_idle_on ? idle_span() : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_word  <= w;
    do @(posedge clk); while (sample_stall);
    filter_and_frame(w);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_filter(input logic [2:0] k, input logic [2:0] q);
    wait_idle();
    apb_write(ADDR_FILTER_SHIFT, 32'(k));
    apb_write(ADDR_QUANT_BITS, 32'(q));
    shift_k = k;
    quant_q = q;
  endtask

  task automatic test_register_defaults();
    logic [31:0] rd;
    apb_read(ADDR_FILTER_SHIFT, rd);
    if (rd != 32'(shift_k)) begin
      report_mismatch($sformatf("filter_shift reads %0d, expected %0d", rd, shift_k));
    end
    apb_read(ADDR_QUANT_BITS, rd);
    if (rd != 32'(quant_q)) begin
      report_mismatch($sformatf("quant_bits reads %0d, expected %0d", rd, quant_q));
    end
  endtask

  task automatic test_directed();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    // full scale, then out of range channels, then zero scale
    for (int i = 0; i < CHANNEL_COUNT; i++) send_sample(3'(i), 12'hFFF);
    send_sample(3'd6, 12'hFFF);
    send_sample(3'd7, 12'h000);
    for (int i = 0; i < CHANNEL_COUNT; i++) send_sample(3'(i), 12'h000);
    // last channel alone, twice in a row
    send_sample(3'(CHANNEL_COUNT - 1), 12'hAAA);
    send_sample(3'(CHANNEL_COUNT - 1), 12'h555);
    // no filtering, heaviest quantization
    set_filter(3'd0, 3'd7);
    send_sample(3'd1, 12'hFFF);
    send_sample(3'(CHANNEL_COUNT - 1), 12'h123);
    // slowest filter, no quantization
    set_filter(3'd7, 3'd0);
    send_sample(3'(CHANNEL_COUNT - 1), 12'hFFF);
    send_sample(3'd0, 12'hFFF);
    send_sample(3'(CHANNEL_COUNT - 1), 12'h001);
  endtask

  task automatic random_phase(input logic [2:0] k, input logic [2:0] q, input int n_items,
                              input bit src_idle, input bit sink_idle);
    int counted;
    int r;
    int stop_at;
    logic [2:0] ch;
    set_filter(k, q);
    src_idle_on  = src_idle;
    sink_idle_on = sink_idle;
    counted = 0;
    while (counted < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        for (int i = 0; i < CHANNEL_COUNT; i++) send_sample(3'(i), pick_sample());
        counted += CHANNEL_COUNT;
      end else if (r < 90) begin
        // broken sequence: partial run, then maybe the last channel
        stop_at = $urandom_range(0, CHANNEL_COUNT - 2);
        for (int i = 0; i <= stop_at; i++) send_sample(3'(i), pick_sample());
        counted += stop_at + 1;
        if ($urandom_range(0, 1)) begin
          send_sample(3'(CHANNEL_COUNT - 1), pick_sample());
          counted++;
        end
      end else begin
        ch = 3'($urandom_range(0, 7));
        send_sample(ch, pick_sample());
        if (ch < CHANNEL_COUNT) counted++;
      end
    end
  endtask

  task automatic test_random();
    random_phase(3'd3, 3'd2, 50, 1'b0, 1'b0);
    random_phase(3'd1, 3'd0, 50, 1'b1, 1'b1);
    random_phase(3'd7, 3'd7, 50, 1'b1, 1'b0);
    random_phase(3'd0, 3'd0, 50, 1'b0, 1'b1);
    random_phase(3'd0, 3'd4, 50, 1'b1, 1'b1);
    random_phase(3'd5, 3'd1, 50, 1'b1, 1'b1);
    random_phase(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 50, 1'b1, 1'b1);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    if (sink_run <= 0) begin
      if (!sink_idle_on || $urandom_range(0, 99) < 65) begin
        sink_hold = 1'b0;
        sink_run  = $urandom_range(1, 12);
      end else begin
        sink_hold = 1'b1;
        sink_run  = idle_span() + 1;
      end
    end
    sink_run--;
    frame_stall <= sink_hold;
  end

  // frame word checker
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && frame_valid && !frame_stall) begin
      if (frame_bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected frame word %02h last %0b",
                                  frame_word.frame_byte, frame_word.frame_last));
      end else begin
        want = frame_bytes_due.pop_front();
        if (frame_word.frame_byte !== want.frame_byte) begin
          report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                    frame_word.frame_byte, want.frame_byte));
        end
        if (frame_word.frame_last !== want.frame_last) begin
          report_mismatch($sformatf("frame_last %0b, expected %0b on byte %02h",
                                    frame_word.frame_last, want.frame_last,
                                    want.frame_byte));
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (frame_valid && !frame_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sample_valid = 1'b0;
    sample_word  = '0;
    frame_stall  = 1'b0;
    sink_hold    = 1'b0;
    sink_run     = 0;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    for (int i = 0; i < CHANNEL_COUNT; i++) chan_level[i] = MIDSCALE;
    shift_k = 3'd3;
    quant_q = 3'd2;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_register_defaults();
    test_directed();
    test_random();

    sample_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frame_bytes_due.size() != 0) begin
      report_mismatch($sformatf("%0d frame words never arrived", frame_bytes_due.size()));
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mefr_pkg.sv
rtl/mefr_front.sv
rtl/mefr_queue.sv
rtl/mefr_back.sv
rtl/multichannel_ema_filter_framer_unit.sv
sim/multichannel_ema_filter_framer_unit_tb.sv
